FILE: sv/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants for the stream duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   // request travelling down the cell chain
   typedef struct packed {
      logic      valid;
      value_type value;
      logic      last;
      logic      found;   // matched a remembered value
      logic      placed;  // remembered in some cell
   } token_type;

endpackage

`default_nettype wire

FILE: sv/sdf_intf.sv
// ----------------------------------------------------------------------------
// sdf_intf
// Request and response channels of the stream duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdf_req_intf;
   logic               valid;
   logic               ready;
   sdf_pkg::value_type value;
   logic               last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface sdf_rsp_intf;
   logic               valid;
   logic               ready;
   sdf_pkg::value_type value_out;
   logic               keep;
   logic               overflow;
   logic               last_out;

   modport source (output valid, output value_out, output keep, output overflow,
                   output last_out, input ready);
   modport sink   (input valid, input value_out, input keep, input overflow,
                   input last_out, output ready);
endinterface

`default_nettype wire

FILE: sv/sdf_cell.sv
// ----------------------------------------------------------------------------
// sdf_cell
// One store slot: compares the passing request, claims the slot for a new
// value, and clears on the list's last element.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire sdf_pkg::token_type tok_i,
   output sdf_pkg::token_type      tok_o
);

   logic               slot_valid_ff, slot_valid_in;
   sdf_pkg::value_type slot_value_ff;
   sdf_pkg::token_type tok_ff, tok_in;
   logic               match, claim;

   always_comb begin
      match         = slot_valid_ff && (slot_value_ff == tok_i.value);
      claim         = tok_i.valid && !slot_valid_ff && !tok_i.found && !tok_i.placed;
      tok_in        = tok_i;
      tok_in.found  = tok_i.found | (tok_i.valid & match);
      tok_in.placed = tok_i.placed | claim;
      slot_valid_in = slot_valid_ff;
      if (tok_i.valid && tok_i.last) begin
         slot_valid_in = 1'b0;
      end else if (claim) begin
         slot_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         tok_ff        <= '0;
      end else if (advance) begin
         slot_valid_ff <= slot_valid_in;
         tok_ff        <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && claim) begin
         slot_value_ff <= tok_i.value;
      end
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

FILE: sv/stream_duplicate_filter_core.sv
// Pipeline: the first cell register loads at request acceptance, then the
//   remaining CAPACITY-1 cells and the response register follow in turn.
// Throughput: one request per cycle; the whole chain holds while a response
//   waits and the response sink is not ready.
// Reset: synchronous, clears all slot valid bits and the in-flight requests.
// ----------------------------------------------------------------------------
// stream_duplicate_filter_core
// Order-preserving duplicate removal over a chain of compare/store cells.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_duplicate_filter_core (
   input  wire logic    clock,
   input  wire logic    reset,
   sdf_req_intf.sink    req_chan,
   sdf_rsp_intf.source  rsp_chan
);

   sdf_pkg::token_type chain [0:sdf_pkg::CAPACITY];
   sdf_pkg::token_type tail;
   logic               advance;
   logic               rsp_valid_ff;
   sdf_pkg::value_type rsp_value_ff;
   logic               rsp_keep_ff, rsp_overflow_ff, rsp_last_ff;

   assign advance = !rsp_valid_ff || rsp_chan.ready;

   // valid, value, last, found, placed
   assign chain[0] = {req_chan.valid, req_chan.value, req_chan.last, 1'b0, 1'b0};

   for (genvar i = 0; i < sdf_pkg::CAPACITY; i++) begin : g_cell
      sdf_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_i   (chain[i]),
         .tok_o   (chain[i+1])
      );
   end

   assign tail = chain[sdf_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff    <= tail.value;
         rsp_keep_ff     <= !tail.found;
         rsp_overflow_ff <= !tail.found && !tail.placed;
         rsp_last_ff     <= tail.last;
      end
   end

   assign req_chan.ready     = advance;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value_out = rsp_value_ff;
   assign rsp_chan.keep      = rsp_keep_ff;
   assign rsp_chan.overflow  = rsp_overflow_ff;
   assign rsp_chan.last_out  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: sv/sdf_checker.sv
// ----------------------------------------------------------------------------
// sdf_checker
// Port-level checks for the stream duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_keep,
   input wire logic rsp_overflow
);

   a_overflow_keeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_keep)
      else $error("overflow response not marked keep");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind stream_duplicate_filter_core sdf_checker u_sdf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_keep     (rsp_chan.keep),
   .rsp_overflow (rsp_chan.overflow)
);

`default_nettype wire

FILE: dv/stream_duplicate_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_duplicate_filter_core_tb
// Streams lists of signed values through the duplicate filter and checks
// each response against a shadow store of the values seen in the current
// list. Covers extreme values, single-element lists, duplicate runs, store
// overflow and a long response hold-off that backs up the request side.
// ----------------------------------------------------------------------------

typedef struct {
   sdf_pkg::value_type value;
   logic               keep;
   logic               overflow;
   logic               last;
} dedup_verdict_type;

class dedup_scoreboard;
   sdf_pkg::value_type seen_store[sdf_pkg::CAPACITY];
   int unsigned        seen_count;
   dedup_verdict_type  pending[$];
   int unsigned        errors;
   int unsigned        num_kept;
   int unsigned        num_dups;
   int unsigned        num_overflows;
   int unsigned        num_lists;
   int unsigned        num_checked;

   function new();
      seen_count = 0;
      errors     = 0;
   endfunction

   // judge one accepted request against the current list's store
   function void note_request(sdf_pkg::value_type v, logic l);
      dedup_verdict_type verdict;
      logic              found;
      found = 1'b0;
      for (int k = 0; k < seen_count; k++)
         if (seen_store[k] == v)
            found = 1'b1;
      verdict.value    = v;
      verdict.last     = l;
      verdict.keep     = !found;
      verdict.overflow = 1'b0;
      if (!found) begin
         if (seen_count < sdf_pkg::CAPACITY) begin
            seen_store[seen_count] = v;
            seen_count++;
         end else begin
            verdict.overflow = 1'b1;
         end
      end
      if (l) begin
         seen_count = 0;
         num_lists++;
      end
      if (verdict.overflow)
         num_overflows++;
      else if (verdict.keep)
         num_kept++;
      else
         num_dups++;
      pending = {pending, verdict};
   endfunction

   task report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
   endtask

   task check_response(input sdf_pkg::value_type v, input logic k, input logic o,
                       input logic l);
      dedup_verdict_type want;
      if (pending.size() == 0) begin
         report_mismatch($sformatf("response %0d with nothing pending", v));
      end else begin
         want = pending.pop_front();
         num_checked++;
         if (v !== want.value || k !== want.keep || o !== want.overflow || l !== want.last)
            report_mismatch($sformatf(
               "got value %0d keep %b ovf %b last %b, want %0d %b %b %b",
               v, k, o, l, want.value, want.keep, want.overflow, want.last));
      end
   endtask
endclass

module stream_duplicate_filter_core_tb;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int HOLD_CYCLES    = 400;

   typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;
   typedef enum int {LIST_SMALL_POOL, LIST_WIDE, LIST_MIXED, LIST_OVERFLOW} list_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sdf_req_intf req_if ();
   sdf_rsp_intf rsp_if ();

   stream_duplicate_filter_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   dedup_scoreboard sb = new();

   int unsigned accepted_requests = 0;
   int unsigned idle_cycles       = 0;
   int unsigned hold_stalls       = 0;
   int unsigned burst_left        = 0;
   int unsigned items_sent        = 0;
   logic        hold_off          = 1'b0;
   rx_mode_type rx_mode           = RX_STEADY;
   int unsigned rx_left           = 0;
   int unsigned rx_phase          = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // handshake monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            sb.note_request(req_if.value, req_if.last);
            accepted_requests++;
         end
         if (rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.value_out, rsp_if.keep, rsp_if.overflow,
                              rsp_if.last_out);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (hold_off && req_if.valid && !req_if.ready)
            hold_stalls++;
      end
   end

   // response sink with its own stall pattern
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rx_phase <= rx_phase + 1;
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
         end else begin
            rx_left <= rx_left - 1;
         end
         if (hold_off) begin
            rsp_if.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_STEADY:   rsp_if.ready <= 1'b1;
               RX_LIGHT:    rsp_if.ready <= ($urandom_range(0, 3) != 0);
               RX_HEAVY:    rsp_if.ready <= ($urandom_range(0, 2) == 0);
               default:     rsp_if.ready <= ((rx_phase % 7) != 0);
            endcase
         end
      end
   end

   // long response hold-off so the chain fills and stalls requests
   initial begin
      wait (accepted_requests >= 600);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no handshake for %0d cycles, %0d responses pending",
               WATCHDOG_LIMIT, sb.pending.size());
      $display("stream_duplicate_filter_core_tb: done, errors");
      $finish;
   end

   task automatic send_request(input sdf_pkg::value_type v, input logic l);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (!hold_off && gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.value <= v;
      req_if.last  <= l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_random_list(input list_kind_type kind, input int unsigned len);
      sdf_pkg::value_type history[$];
      sdf_pkg::value_type base;
      sdf_pkg::value_type v;
      base = sdf_pkg::value_type'($urandom);
      for (int unsigned i = 0; i < len; i++) begin
         case (kind)
            LIST_SMALL_POOL: v = sdf_pkg::value_type'($urandom_range(0, 15)) - 8;
            LIST_WIDE:       v = sdf_pkg::value_type'($urandom);
            LIST_MIXED: begin
               if (history.size() != 0 && $urandom_range(0, 1) == 0)
                  v = history[$urandom_range(0, history.size() - 1)];
               else
                  case ($urandom_range(0, 5))
                     0: v = {1'b1, {(sdf_pkg::VALUE_WIDTH-1){1'b0}}};
                     1: v = {1'b0, {(sdf_pkg::VALUE_WIDTH-1){1'b1}}};
                     2: v = '0;
                     3: v = '1;
                     default: v = sdf_pkg::value_type'($urandom);
                  endcase
            end
            default: begin
               // fill the store with distinct values, then mix repeats and new ones
               if (i < sdf_pkg::CAPACITY || $urandom_range(0, 2) != 0)
                  v = base + sdf_pkg::value_type'(i);
               else
                  v = history[$urandom_range(0, history.size() - 1)];
            end
         endcase
         history = {history, v};
         send_request(v, i == len - 1);
      end
   endtask

   initial begin
      list_kind_type kind;
      int unsigned   len;
      int unsigned   pick;
      int unsigned   start_count;

      req_if.valid = 1'b0;
      req_if.value = '0;
      req_if.last  = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, duplicates, single-element lists, fresh list after last
      send_request({1'b1, {(sdf_pkg::VALUE_WIDTH-1){1'b0}}}, 1'b1);
      send_request({1'b0, {(sdf_pkg::VALUE_WIDTH-1){1'b1}}}, 1'b0);
      send_request({1'b1, {(sdf_pkg::VALUE_WIDTH-1){1'b0}}}, 1'b0);
      send_request('0, 1'b0);
      send_request('1, 1'b0);
      send_request({1'b0, {(sdf_pkg::VALUE_WIDTH-1){1'b1}}}, 1'b0);
      send_request('0, 1'b0);
      send_request('1, 1'b0);
      send_request(32'h5555_5555, 1'b0);
      send_request(32'hAAAA_AAAA, 1'b0);
      send_request({1'b1, {(sdf_pkg::VALUE_WIDTH-1){1'b0}}}, 1'b1);
      send_request({1'b1, {(sdf_pkg::VALUE_WIDTH-1){1'b0}}}, 1'b0);
      send_request('0, 1'b1);
      send_request('0, 1'b1);
      send_request('0, 1'b1);
      send_request(32'd1, 1'b0);
      send_request(32'd1, 1'b0);
      send_request(32'd1, 1'b1);

      // random lists; the first always overruns the store
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (items_sent - start_count < 2 * sdf_pkg::CAPACITY + 80 && sb.num_overflows == 0)
            pick = 0;
         if (pick == 0) begin
            kind = LIST_OVERFLOW;
            len  = $urandom_range(sdf_pkg::CAPACITY + 1, sdf_pkg::CAPACITY + 36);
         end else begin
            kind = list_kind_type'($urandom_range(0, 2));
            len  = (pick < 3) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         end
         send_random_list(kind, len);
      end
      req_if.valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (sdf_pkg::CAPACITY + 20) @(posedge clock);

      $display("covered %0d requests in %0d lists: %0d new, %0d duplicate, %0d overflow",
               accepted_requests, sb.num_lists, sb.num_kept, sb.num_dups,
               sb.num_overflows);
      $display("request side stalled %0d cycles under response hold-off; %0d checked",
               hold_stalls, sb.num_checked);
      if (sb.errors == 0)
         $display("stream_duplicate_filter_core_tb: done, clean");
      else
         $display("stream_duplicate_filter_core_tb: done, errors");
      $finish;
   end

endmodule
